### src/speck_pkg.sv
package speck_pkg;

	// Cipher geometry.
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned ROUNDS    = 34;
	localparam int unsigned RND_W     = $clog2(ROUNDS);
	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned ROT_A     = 8;
	localparam int unsigned ROT_B     = 3;
	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [RND_W-1:0]  rnd_idx_t;
	typedef word_t             key_arr_t [KEY_WORDS];

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY0 = 4'd0,
		CFG_KEY1 = 4'd1,
		CFG_KEY2 = 4'd2,
		CFG_KEY3 = 4'd3
	} cfg_idx_t;

	// Block actions.
	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_PRIME,
		ST_ROUND,
		ST_DONE
	} state_t;

	// Controls for the key schedule unit.
	typedef struct packed {
		logic load;
		logic step;
	} ks_ctrl_t;

	// Controls for the round unit.
	typedef struct packed {
		logic load;
		logic step;
		logic decrypt;
	} rnd_ctrl_t;

	function automatic word_t rol(word_t v, int unsigned r);
		return (v << r) | (v >> (WORD_W - r));
	endfunction

	function automatic word_t ror(word_t v, int unsigned r);
		return (v >> r) | (v << (WORD_W - r));
	endfunction

endpackage

### src/speck_in_if.sv
interface speck_in_if;
	import speck_pkg::*;

	logic  valid;
	logic  ready;
	logic  action;
	word_t block_low;
	word_t block_high;

	modport source (output valid, action, block_low, block_high, input ready);
	modport sink (input valid, action, block_low, block_high, output ready);
endinterface

### src/speck_out_if.sv
interface speck_out_if;
	import speck_pkg::*;

	logic  valid;
	logic  ready;
	word_t result_low;
	word_t result_high;

	modport source (output valid, result_low, result_high, input ready);
	modport sink (input valid, result_low, result_high, output ready);
endinterface

### src/speck_cfg_if.sv
interface speck_cfg_if;
	import speck_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	word_t                data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/speck128_256_cipher.sv
// Channel  Direction  Payload
// -------  ---------  ------------------------------------------------
// blk_in   sink       action, block_low (y), block_high (x)
// blk_out  source     result_low (y), result_high (x)
// cfg      sink       index (0..3 key words), data; always ready
//
// After its transfer a block passes through a read-priming state, the rounds
// in the shared round unit and a state that loads the output register, and
// then returns to idle.
// The first block after a key write first runs the key schedule.
// blk_in is ready only in idle; a finished block holds until the output
// register is free. Reset clears the key words and marks the schedule stale.
module speck128_256_cipher (
	input  logic        clk,
	input  logic        arst_n,
	speck_in_if.sink    blk_in,
	speck_out_if.source blk_out,
	speck_cfg_if.sink   cfg
);
	import speck_pkg::*;

	state_t    state_q;
	state_t    state_d;
	rnd_idx_t  cnt_q;
	logic      cnt_clr;
	logic      cnt_inc;
	logic      sched_valid_q;
	logic      decrypt_q;
	key_arr_t  key_q;
	ks_ctrl_t  ks_ctrl;
	rnd_ctrl_t rnd_ctrl;
	word_t     ks_rk;
	word_t     mem_rd_data;
	rnd_idx_t  rd_addr;
	rnd_idx_t  nxt_idx;
	logic      mem_wr_en;
	word_t     y;
	word_t     x;
	logic      in_xfer;
	logic      out_load;
	logic      out_valid_q;
	word_t     out_low_q;
	word_t     out_high_q;

	assign in_xfer = blk_in.valid & blk_in.ready;

	// Key registers; any key write marks the schedule stale.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_KEY0: key_q[0] <= cfg.data;
				CFG_KEY1: key_q[1] <= cfg.data;
				CFG_KEY2: key_q[2] <= cfg.data;
				CFG_KEY3: key_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_valid_q <= 1'b0;
		end else if (cfg.valid && cfg.index < CFG_IDX_W'(KEY_WORDS)) begin
			sched_valid_q <= 1'b0;
		end else if (state_q == ST_EXPAND && cnt_q == RND_LAST) begin
			sched_valid_q <= 1'b1;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = sched_valid_q ? ST_PRIME : ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				if (cnt_q == RND_LAST) begin
					state_d = ST_PRIME;
				end
			end
			ST_PRIME: state_d = ST_ROUND;
			ST_ROUND: begin
				if (cnt_q == RND_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || blk_out.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		blk_in.ready     = 1'b0;
		cnt_clr          = 1'b0;
		cnt_inc          = 1'b0;
		mem_wr_en        = 1'b0;
		ks_ctrl.load     = 1'b0;
		ks_ctrl.step     = 1'b0;
		rnd_ctrl.load    = 1'b0;
		rnd_ctrl.step    = 1'b0;
		rnd_ctrl.decrypt = decrypt_q;
		out_load         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				blk_in.ready  = 1'b1;
				cnt_clr       = 1'b1;
				ks_ctrl.load  = in_xfer;
				rnd_ctrl.load = in_xfer;
			end
			ST_EXPAND: begin
				cnt_inc      = 1'b1;
				mem_wr_en    = 1'b1;
				ks_ctrl.step = 1'b1;
			end
			ST_PRIME: cnt_clr = 1'b1;
			ST_ROUND: begin
				cnt_inc       = 1'b1;
				rnd_ctrl.step = 1'b1;
			end
			ST_DONE: out_load = !out_valid_q || blk_out.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			decrypt_q <= blk_in.action;
		end
	end

	// Round key read address runs one round ahead of the round unit.
	always_comb begin
		nxt_idx = '0;
		if (state_q == ST_ROUND && cnt_q != RND_LAST) begin
			nxt_idx = cnt_q + 1'b1;
		end
		rd_addr = (decrypt_q == ACT_DECRYPT) ? RND_LAST - nxt_idx : nxt_idx;
	end

	speck_ks_unit u_ks (
		.clk      (clk),
		.ctrl     (ks_ctrl),
		.key      (key_q),
		.step_idx (cnt_q),
		.rk       (ks_rk)
	);

	speck_rk_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (cnt_q),
		.wr_data (ks_rk),
		.rd_addr (rd_addr),
		.rd_data (mem_rd_data)
	);

	speck_round_unit u_round (
		.clk     (clk),
		.ctrl    (rnd_ctrl),
		.in_low  (blk_in.block_low),
		.in_high (blk_in.block_high),
		.rk      (mem_rd_data),
		.y       (y),
		.x       (x)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (blk_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_low_q  <= y;
			out_high_q <= x;
		end
	end

	assign blk_out.valid       = out_valid_q;
	assign blk_out.result_low  = out_low_q;
	assign blk_out.result_high = out_high_q;
endmodule

### src/speck_rk_mem.sv
module speck_rk_mem (
	input  logic              clk,
	input  logic              wr_en,
	input  speck_pkg::rnd_idx_t wr_addr,
	input  speck_pkg::word_t  wr_data,
	input  speck_pkg::rnd_idx_t rd_addr,
	output speck_pkg::word_t  rd_data
);
	import speck_pkg::*;

	word_t mem_q [ROUNDS];
	word_t rd_data_q;

	// One write port for the key schedule.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port for the round unit.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

### src/speck_ks_unit.sv
module speck_ks_unit (
	input  logic                clk,
	input  speck_pkg::ks_ctrl_t ctrl,
	input  speck_pkg::key_arr_t key,
	input  speck_pkg::rnd_idx_t step_idx,
	output speck_pkg::word_t    rk
);
	import speck_pkg::*;

	word_t k_q;
	word_t l_q [3];
	word_t nl;
	word_t k_nxt;

	// One schedule step: new l word, then the next round key.
	always_comb begin
		nl    = (k_q + ror(l_q[0], ROT_A)) ^ WORD_W'(step_idx);
		k_nxt = rol(k_q, ROT_B) ^ nl;
	end

	// The l words form a short shift line.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			k_q    <= key[0];
			l_q[0] <= key[1];
			l_q[1] <= key[2];
			l_q[2] <= key[3];
		end else if (ctrl.step) begin
			k_q    <= k_nxt;
			l_q[0] <= l_q[1];
			l_q[1] <= l_q[2];
			l_q[2] <= nl;
		end
	end

	assign rk = k_q;
endmodule

### src/speck_round_unit.sv
module speck_round_unit (
	input  logic                 clk,
	input  speck_pkg::rnd_ctrl_t ctrl,
	input  speck_pkg::word_t     in_low,
	input  speck_pkg::word_t     in_high,
	input  speck_pkg::word_t     rk,
	output speck_pkg::word_t     y,
	output speck_pkg::word_t     x
);
	import speck_pkg::*;

	word_t y_q;
	word_t x_q;
	word_t y_nxt;
	word_t x_nxt;

	// One ARX round, forward or inverse.
	always_comb begin
		if (ctrl.decrypt == ACT_DECRYPT) begin
			y_nxt = ror(y_q ^ x_q, ROT_B);
			x_nxt = rol((x_q ^ rk) - y_nxt, ROT_A);
		end else begin
			x_nxt = (ror(x_q, ROT_A) + y_q) ^ rk;
			y_nxt = rol(y_q, ROT_B) ^ x_nxt;
		end
	end

	// Block state registers.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			y_q <= in_low;
			x_q <= in_high;
		end else if (ctrl.step) begin
			y_q <= y_nxt;
			x_q <= x_nxt;
		end
	end

	assign y = y_q;
	assign x = x_q;
endmodule

### src/speck_checker.sv
module speck_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input speck_pkg::word_t out_low,
	input speck_pkg::word_t out_high
);
	import speck_pkg::*;

	logic in_xfer;

	assign in_xfer = in_valid & in_ready;

	// The block is busy once it has taken a block.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input ready right after an input transfer");

	// No new result can follow an input transfer in the next cycle.
	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !out_valid |=> !out_valid)
		else $error("result shown one cycle after an input transfer");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before its transfer");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_low) && $stable(out_high))
		else $error("result changed while stalled");
endmodule

bind speck128_256_cipher speck_checker u_speck_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (blk_in.valid),
	.in_ready  (blk_in.ready),
	.out_valid (blk_out.valid),
	.out_ready (blk_out.ready),
	.out_low   (blk_out.result_low),
	.out_high  (blk_out.result_high)
);
